/* hw/rtl/ttpfb_pkg.sv */
// Package for the text-to-page framebuffer: transfer structs, opcodes, controller states,
// command/status groups and the 5x7 font table with its character lookup.
// No dependencies.
package ttpfb_pkg;

   localparam int PAGES_DEF    = 8;
   localparam int COLUMNS_DEF  = 128;
   localparam int GLYPH_WIDTH  = 5;
   localparam int CELL_WIDTH   = 6;
   localparam int GLYPH_COUNT  = 43;
   localparam int GLYPH_IDX_W  = 6;
   localparam int COL_W        = 9;
   localparam int PAGE_W       = 4;
   localparam int ADDR_W       = 10;
   localparam int CODE_W       = 8;
   localparam int DATA_W       = 8;

   localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

   localparam logic [GLYPH_IDX_W-1:0] G_BLANK    = 6'd36;
   localparam logic [GLYPH_IDX_W-1:0] G_DASH     = 6'd37;
   localparam logic [GLYPH_IDX_W-1:0] G_DOT      = 6'd38;
   localparam logic [GLYPH_IDX_W-1:0] G_COLON    = 6'd39;
   localparam logic [GLYPH_IDX_W-1:0] G_SLASH    = 6'd40;
   localparam logic [GLYPH_IDX_W-1:0] G_UNDER    = 6'd41;
   localparam logic [GLYPH_IDX_W-1:0] G_FALLBACK = 6'd42;

   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_PLACE = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_DRAW,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [CODE_W-1:0] char_code;
      logic [ADDR_W-1:0] read_address;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              char_drawn;
      logic              text_full;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic sweep;
      logic draw;
   } cmd_type;

   typedef struct packed {
      logic will_draw;
      logic sweep_last;
      logic draw_last;
   } status_type;

   localparam logic [DATA_W-1:0] FONT_ROM [GLYPH_COUNT][GLYPH_WIDTH] = '{
      '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
      '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
      '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
      '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
      '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
      '{8'h7E,8'h11,8'h11,8'h11,8'h7E}, '{8'h7F,8'h49,8'h49,8'h49,8'h36},
      '{8'h3E,8'h41,8'h41,8'h41,8'h22}, '{8'h7F,8'h41,8'h41,8'h22,8'h1C},
      '{8'h7F,8'h49,8'h49,8'h49,8'h41}, '{8'h7F,8'h09,8'h09,8'h09,8'h01},
      '{8'h3E,8'h41,8'h49,8'h49,8'h7A}, '{8'h7F,8'h08,8'h08,8'h08,8'h7F},
      '{8'h00,8'h41,8'h7F,8'h41,8'h00}, '{8'h20,8'h40,8'h41,8'h3F,8'h01},
      '{8'h7F,8'h08,8'h14,8'h22,8'h41}, '{8'h7F,8'h40,8'h40,8'h40,8'h40},
      '{8'h7F,8'h02,8'h0C,8'h02,8'h7F}, '{8'h7F,8'h04,8'h08,8'h10,8'h7F},
      '{8'h3E,8'h41,8'h41,8'h41,8'h3E}, '{8'h7F,8'h09,8'h09,8'h09,8'h06},
      '{8'h3E,8'h41,8'h51,8'h21,8'h5E}, '{8'h7F,8'h09,8'h19,8'h29,8'h46},
      '{8'h46,8'h49,8'h49,8'h49,8'h31}, '{8'h01,8'h01,8'h7F,8'h01,8'h01},
      '{8'h3F,8'h40,8'h40,8'h40,8'h3F}, '{8'h1F,8'h20,8'h40,8'h20,8'h1F},
      '{8'h3F,8'h40,8'h38,8'h40,8'h3F}, '{8'h63,8'h14,8'h08,8'h14,8'h63},
      '{8'h07,8'h08,8'h70,8'h08,8'h07}, '{8'h61,8'h51,8'h49,8'h45,8'h43},
      '{8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h08,8'h08,8'h08,8'h08,8'h08},
      '{8'h00,8'h60,8'h60,8'h00,8'h00},
      '{8'h00,8'h36,8'h36,8'h00,8'h00},
      '{8'h20,8'h10,8'h08,8'h04,8'h02},
      '{8'h40,8'h40,8'h40,8'h40,8'h40},
      '{8'h02,8'h01,8'h59,8'h09,8'h06}
   };

   function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0]      c;
      logic [GLYPH_IDX_W-1:0] g;
      c = code;
      if (c >= "a" && c <= "z") begin
         c = c - 8'd32;
      end
      if (c == " ") begin
         g = G_BLANK;
      end else if (c >= "0" && c <= "9") begin
         g = GLYPH_IDX_W'(c - "0");
      end else if (c >= "A" && c <= "Z") begin
         g = GLYPH_IDX_W'(c - "A") + 6'd10;
      end else if (c == "-") begin
         g = G_DASH;
      end else if (c == ".") begin
         g = G_DOT;
      end else if (c == ":") begin
         g = G_COLON;
      end else if (c == "/") begin
         g = G_SLASH;
      end else if (c == "_") begin
         g = G_UNDER;
      end else begin
         g = G_FALLBACK;
      end
      return g;
   endfunction

   function automatic logic [DATA_W-1:0] font_column(input logic [GLYPH_IDX_W-1:0] g,
                                                      input logic [2:0] col);
      logic [DATA_W-1:0] d;
      d = '0;
      if (g < GLYPH_IDX_W'(GLYPH_COUNT) && col < 3'(GLYPH_WIDTH)) begin
         d = FONT_ROM[g][col];
      end
      return d;
   endfunction

endpackage

/* hw/rtl/ttpfb_ctrl.sv */
// Controller state machine of the text-to-page framebuffer.
// Depends on ttpfb_pkg (states, opcodes, command and status groups).
module ttpfb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           opcode,
   input  ttpfb_pkg::status_type status,
   output logic                 busy,
   output logic                 rsp_valid,
   output ttpfb_pkg::cmd_type   cmd
);

   ttpfb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttpfb_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ttpfb_pkg::ST_INIT: begin
            if (status.sweep_last) begin
               state_in = ttpfb_pkg::ST_IDLE;
            end
         end
         ttpfb_pkg::ST_IDLE: begin
            if (start) begin
               if (opcode == ttpfb_pkg::OP_BEGIN) begin
                  state_in = ttpfb_pkg::ST_CLEAR;
               end else if (opcode == ttpfb_pkg::OP_PLACE && status.will_draw) begin
                  state_in = ttpfb_pkg::ST_DRAW;
               end else begin
                  state_in = ttpfb_pkg::ST_RESP;
               end
            end
         end
         ttpfb_pkg::ST_CLEAR: begin
            if (status.sweep_last) begin
               state_in = ttpfb_pkg::ST_RESP;
            end
         end
         ttpfb_pkg::ST_DRAW: begin
            if (status.draw_last) begin
               state_in = ttpfb_pkg::ST_RESP;
            end
         end
         ttpfb_pkg::ST_RESP: begin
            state_in = ttpfb_pkg::ST_IDLE;
         end
         default: begin
            state_in = ttpfb_pkg::ST_INIT;
         end
      endcase
   end

   always_comb begin
      busy       = (state_ff != ttpfb_pkg::ST_IDLE);
      rsp_valid  = (state_ff == ttpfb_pkg::ST_RESP);
      cmd.accept = (state_ff == ttpfb_pkg::ST_IDLE) && start;
      cmd.sweep  = (state_ff == ttpfb_pkg::ST_INIT) || (state_ff == ttpfb_pkg::ST_CLEAR);
      cmd.draw   = (state_ff == ttpfb_pkg::ST_DRAW);
   end

endmodule

/* hw/rtl/ttpfb_datapath.sv */
// Datapath of the text-to-page framebuffer: frame store, cursor, full flag, glyph writer.
// Depends on ttpfb_pkg (structs, font table, glyph lookup).
module ttpfb_datapath #(
   parameter int PAGES   = ttpfb_pkg::PAGES_DEF,
   parameter int COLUMNS = ttpfb_pkg::COLUMNS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ttpfb_pkg::cmd_type    cmd,
   input  ttpfb_pkg::req_type    req_item,
   output ttpfb_pkg::status_type status,
   output ttpfb_pkg::rsp_type    rsp_item
);

   localparam int STORE_SIZE = PAGES * COLUMNS;
   localparam int SAW        = $clog2(STORE_SIZE);
   localparam int CMP_W      = (SAW > ttpfb_pkg::ADDR_W) ? SAW : ttpfb_pkg::ADDR_W;
   localparam int COL_W      = ttpfb_pkg::COL_W;
   localparam int PAGE_W     = ttpfb_pkg::PAGE_W;
   localparam logic [SAW-1:0]    COLS_A     = SAW'(COLUMNS);
   localparam logic [COL_W-1:0]  WRAP_LIMIT = COL_W'(COLUMNS - ttpfb_pkg::CELL_WIDTH);
   localparam logic [PAGE_W-1:0] LAST_PAGE  = PAGE_W'(PAGES - 1);

   logic [ttpfb_pkg::DATA_W-1:0] mem [STORE_SIZE];

   logic [COL_W-1:0]                 col_ff, col_in;
   logic [PAGE_W-1:0]                page_ff, page_in;
   logic                             full_ff, full_in;
   logic [SAW-1:0]                   cnt_ff;
   logic [SAW-1:0]                   base_ff;
   logic [ttpfb_pkg::GLYPH_IDX_W-1:0] glyph_ff;
   logic                             drawn_ff;
   logic                             rd_sel_ff;
   logic [ttpfb_pkg::DATA_W-1:0]     rd_data_ff;

   logic                             is_place, is_read, is_begin;
   logic                             newline, wrap_need, last_page, will_draw;
   logic [COL_W-1:0]                 col_sel;
   logic [PAGE_W-1:0]                page_sel;
   logic [SAW-1:0]                   base_in;
   logic [CMP_W:0]                   addr_ext;
   logic                             in_range;
   logic                             we;
   logic [SAW-1:0]                   wr_addr;
   logic [ttpfb_pkg::DATA_W-1:0]     wr_data;

   assign is_begin  = (req_item.opcode == ttpfb_pkg::OP_BEGIN);
   assign is_place  = (req_item.opcode == ttpfb_pkg::OP_PLACE);
   assign is_read   = (req_item.opcode == ttpfb_pkg::OP_READ);
   assign newline   = (req_item.char_code == ttpfb_pkg::NEWLINE_CODE);
   assign wrap_need = (col_ff > WRAP_LIMIT);
   assign last_page = (page_ff == LAST_PAGE);
   assign will_draw = !full_ff && !newline && !(wrap_need && last_page);

   assign col_sel  = wrap_need ? '0 : col_ff;
   assign page_sel = wrap_need ? page_ff + 1'b1 : page_ff;
   assign base_in  = SAW'(page_sel) * COLS_A + SAW'(col_sel);

   assign addr_ext = (CMP_W+1)'(req_item.read_address);
   assign in_range = (addr_ext < (CMP_W+1)'(STORE_SIZE));

   always_comb begin
      col_in  = col_ff;
      page_in = page_ff;
      full_in = full_ff;
      if (cmd.accept && is_begin) begin
         col_in  = '0;
         page_in = '0;
         full_in = 1'b0;
      end else if (cmd.accept && is_place && !full_ff) begin
         if (newline || wrap_need) begin
            col_in = '0;
            if (last_page) begin
               full_in = 1'b1;
            end else begin
               page_in = page_ff + 1'b1;
            end
         end
         if (will_draw) begin
            col_in = col_sel + COL_W'(ttpfb_pkg::CELL_WIDTH);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         page_ff <= '0;
         full_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         col_ff  <= col_in;
         page_ff <= page_in;
         full_ff <= full_in;
         if (cmd.accept) begin
            cnt_ff <= '0;
         end else if (cmd.sweep || cmd.draw) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         base_ff   <= base_in;
         glyph_ff  <= ttpfb_pkg::glyph_index(req_item.char_code);
         drawn_ff  <= is_place && will_draw;
         rd_sel_ff <= is_read && in_range;
      end
   end

   assign we      = cmd.sweep || cmd.draw;
   assign wr_addr = cmd.sweep ? cnt_ff : base_ff + cnt_ff;
   assign wr_data = cmd.sweep ? '0 : ttpfb_pkg::font_column(glyph_ff, cnt_ff[2:0]);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.accept && is_read && in_range) begin
         rd_data_ff <= mem[addr_ext[SAW-1:0]];
      end
   end

   assign status.will_draw  = will_draw;
   assign status.sweep_last = (cnt_ff == SAW'(STORE_SIZE - 1));
   assign status.draw_last  = (cnt_ff == SAW'(ttpfb_pkg::CELL_WIDTH - 1));

   assign rsp_item.read_data  = rd_sel_ff ? rd_data_ff : '0;
   assign rsp_item.char_drawn = drawn_ff;
   assign rsp_item.text_full  = full_ff;

endmodule

/* hw/rtl/text_to_page_framebuffer_unit.sv */
// Top level of the text-to-page framebuffer: 5x7 text into a paged monochrome store.
// Depends on ttpfb_pkg, ttpfb_ctrl and ttpfb_datapath.
//
//   channel   handshake                 payload
//   request   start / busy              req_item (opcode, char_code, read_address)
//   response  rsp_valid (one-cycle)     rsp_item (read_data, char_drawn, text_full)
//
// From accept to the next accept, a begin clears the whole store and a drawn character writes
// its cell, with busy high until the result; the single-port frame store writes one byte per cycle.
// After reset busy stays high while the store is cleared.
// The result appears on rsp_item for exactly one cycle with rsp_valid; no stall input.
module text_to_page_framebuffer_unit #(
   parameter int PAGES   = ttpfb_pkg::PAGES_DEF,
   parameter int COLUMNS = ttpfb_pkg::COLUMNS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ttpfb_pkg::req_type req_item,
   output logic               rsp_valid,
   output ttpfb_pkg::rsp_type rsp_item
);

   ttpfb_pkg::cmd_type    cmd;
   ttpfb_pkg::status_type status;

   ttpfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .opcode    (req_item.opcode),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   ttpfb_datapath #(
      .PAGES   (PAGES),
      .COLUMNS (COLUMNS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule

/* tb/sv/text_to_page_framebuffer_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for text_to_page_framebuffer_unit: a directed table, then random text
// sessions, each result checked against a pinned value or a local model of the page store. Depends on ttpfb_pkg.
module text_to_page_framebuffer_unit_tb;

   localparam int PAGES        = 8;
   localparam int COLUMNS      = 128;
   localparam int STORE_BYTES  = PAGES * COLUMNS;
   localparam int GLYPH_W      = 5;
   localparam int CELL         = 6;
   localparam int RANDOM_ITEMS = 1200;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int TAIL_CYCLES  = 16;

   localparam logic [1:0] OP_SPARE  = 2'd3;
   localparam logic [7:0] LINE_FEED = 8'd10;

   localparam int GL_BLANK    = 36;
   localparam int GL_DASH     = 37;
   localparam int GL_DOT      = 38;
   localparam int GL_COLON    = 39;
   localparam int GL_SLASH    = 40;
   localparam int GL_UNDER    = 41;
   localparam int GL_FALLBACK = 42;

   localparam logic [7:0] GLYPH_COLS [43][GLYPH_W] = '{
      '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
      '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
      '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
      '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
      '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
      '{8'h7E,8'h11,8'h11,8'h11,8'h7E}, '{8'h7F,8'h49,8'h49,8'h49,8'h36},
      '{8'h3E,8'h41,8'h41,8'h41,8'h22}, '{8'h7F,8'h41,8'h41,8'h22,8'h1C},
      '{8'h7F,8'h49,8'h49,8'h49,8'h41}, '{8'h7F,8'h09,8'h09,8'h09,8'h01},
      '{8'h3E,8'h41,8'h49,8'h49,8'h7A}, '{8'h7F,8'h08,8'h08,8'h08,8'h7F},
      '{8'h00,8'h41,8'h7F,8'h41,8'h00}, '{8'h20,8'h40,8'h41,8'h3F,8'h01},
      '{8'h7F,8'h08,8'h14,8'h22,8'h41}, '{8'h7F,8'h40,8'h40,8'h40,8'h40},
      '{8'h7F,8'h02,8'h0C,8'h02,8'h7F}, '{8'h7F,8'h04,8'h08,8'h10,8'h7F},
      '{8'h3E,8'h41,8'h41,8'h41,8'h3E}, '{8'h7F,8'h09,8'h09,8'h09,8'h06},
      '{8'h3E,8'h41,8'h51,8'h21,8'h5E}, '{8'h7F,8'h09,8'h19,8'h29,8'h46},
      '{8'h46,8'h49,8'h49,8'h49,8'h31}, '{8'h01,8'h01,8'h7F,8'h01,8'h01},
      '{8'h3F,8'h40,8'h40,8'h40,8'h3F}, '{8'h1F,8'h20,8'h40,8'h20,8'h1F},
      '{8'h3F,8'h40,8'h38,8'h40,8'h3F}, '{8'h63,8'h14,8'h08,8'h14,8'h63},
      '{8'h07,8'h08,8'h70,8'h08,8'h07}, '{8'h61,8'h51,8'h49,8'h45,8'h43},
      '{8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h08,8'h08,8'h08,8'h08,8'h08},
      '{8'h00,8'h60,8'h60,8'h00,8'h00},
      '{8'h00,8'h36,8'h36,8'h00,8'h00},
      '{8'h20,8'h10,8'h08,8'h04,8'h02},
      '{8'h40,8'h40,8'h40,8'h40,8'h40},
      '{8'h02,8'h01,8'h59,8'h09,8'h06}
   };

   typedef struct packed {
      ttpfb_pkg::req_type item;
      logic               pinned;
      ttpfb_pkg::rsp_type want;
   } probe_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   ttpfb_pkg::req_type req_item = '0;
   logic               busy;
   logic               rsp_valid;
   ttpfb_pkg::rsp_type rsp_item;

   logic [7:0] page_bytes [STORE_BYTES];
   int         pen_col = 0;
   int         pen_page = 0;
   bit         page_full = 1'b0;

   ttpfb_pkg::rsp_type awaited_rsps [$];
   int                 mismatches = 0;
   int                 cycles = 0;
   int                 burst_left = 4;
   probe_row_type      script [27];

   text_to_page_framebuffer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic probe_row_type row(logic [1:0] op, logic [7:0] code, logic [9:0] addr,
                                         bit pinned, logic [7:0] data, bit drawn, bit full);
      probe_row_type p;
      p.item.opcode       = op;
      p.item.char_code    = code;
      p.item.read_address = addr;
      p.pinned            = pinned;
      p.want.read_data    = data;
      p.want.char_drawn   = drawn;
      p.want.text_full    = full;
      return p;
   endfunction

   function automatic bit next_line();
      pen_col = 0;
      if (pen_page + 1 >= PAGES) begin
         page_full = 1'b1;
         return 1'b0;
      end
      pen_page++;
      return 1'b1;
   endfunction

   function automatic ttpfb_pkg::rsp_type render_step(ttpfb_pkg::req_type r);
      ttpfb_pkg::rsp_type o;
      logic [7:0]         c;
      int                 g;
      int                 base;
      int                 i;
      bit                 room;
      o = '0;
      case (r.opcode)
         ttpfb_pkg::OP_BEGIN: begin
            foreach (page_bytes[k]) page_bytes[k] = '0;
            pen_col   = 0;
            pen_page  = 0;
            page_full = 1'b0;
         end
         ttpfb_pkg::OP_PLACE: begin
            if (!page_full && r.char_code == LINE_FEED) begin
               void'(next_line());
            end else if (!page_full) begin
               room = (pen_col > COLUMNS - CELL) ? next_line() : 1'b1;
               if (room) begin
                  c = r.char_code;
                  if (c >= "a" && c <= "z") c = c - 8'd32;
                  if (c == " ") g = GL_BLANK;
                  else if (c >= "0" && c <= "9") g = c - "0";
                  else if (c >= "A" && c <= "Z") g = c - "A" + 10;
                  else if (c == "-") g = GL_DASH;
                  else if (c == ".") g = GL_DOT;
                  else if (c == ":") g = GL_COLON;
                  else if (c == "/") g = GL_SLASH;
                  else if (c == "_") g = GL_UNDER;
                  else g = GL_FALLBACK;
                  base = pen_page * COLUMNS + pen_col;
                  for (i = 0; i < GLYPH_W; i++) begin
                     if (base + i < STORE_BYTES) page_bytes[base + i] = GLYPH_COLS[g][i];
                  end
                  if (base + GLYPH_W < STORE_BYTES) page_bytes[base + GLYPH_W] = '0;
                  pen_col += CELL;
                  o.char_drawn = 1'b1;
               end
            end
         end
         ttpfb_pkg::OP_READ: begin
            if (r.read_address < STORE_BYTES) o.read_data = page_bytes[r.read_address];
         end
         default: ;
      endcase
      o.text_full = page_full;
      return o;
   endfunction

   function automatic logic [7:0] pick_char(int nl_pct);
      int p;
      p = $urandom_range(0, 99);
      if (p < nl_pct) return LINE_FEED;
      if (p < 45) return 8'("A" + $urandom_range(0, 25));
      if (p < 60) return 8'("a" + $urandom_range(0, 25));
      if (p < 72) return 8'("0" + $urandom_range(0, 9));
      if (p < 86) begin
         case ($urandom_range(0, 5))
            0: return " ";
            1: return "-";
            2: return ".";
            3: return ":";
            4: return "/";
            default: return "_";
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send(ttpfb_pkg::req_type item, bit pinned, ttpfb_pkg::rsp_type want);
      ttpfb_pkg::rsp_type guess;
      req_item <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      guess = render_step(item);
      awaited_rsps.push_back(pinned ? want : guess);
   endtask

   task automatic idle(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic pace();
      if (burst_left == 0) begin
         idle($urandom_range(1, 12));
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (awaited_rsps.size() != 0);
   endtask

   always @(posedge clock) begin
      ttpfb_pkg::rsp_type exp_rsp;
      cycles++;
      if (!reset && rsp_valid) begin
         if (awaited_rsps.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected, actual %h", $time, rsp_item);
         end else begin
            exp_rsp = awaited_rsps.pop_front();
            if (rsp_item.read_data !== exp_rsp.read_data) begin
               mismatches++;
               $display("%0t: read_data expected %h actual %h", $time,
                        exp_rsp.read_data, rsp_item.read_data);
            end
            if (rsp_item.char_drawn !== exp_rsp.char_drawn) begin
               mismatches++;
               $display("%0t: char_drawn expected %b actual %b", $time,
                        exp_rsp.char_drawn, rsp_item.char_drawn);
            end
            if (rsp_item.text_full !== exp_rsp.text_full) begin
               mismatches++;
               $display("%0t: text_full expected %b actual %b", $time,
                        exp_rsp.text_full, rsp_item.text_full);
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, awaited_rsps.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      ttpfb_pkg::req_type item;
      int                 issued;
      int                 session;
      int                 len;
      int                 nl_pct;
      int                 pick;
      int                 j;
      bit                 counts;
      foreach (page_bytes[k]) page_bytes[k] = '0;
      script = '{
         row(ttpfb_pkg::OP_READ,  8'h00, 10'd0,    1, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_READ,  8'h00, 10'd1023, 1, 8'h00, 0, 0),
         row(OP_SPARE,            8'hFF, 10'h3FF,  1, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, "A",   10'd0,    1, 8'h00, 1, 0),
         row(ttpfb_pkg::OP_READ,  8'h00, 10'd0,    1, 8'h7E, 0, 0),
         row(ttpfb_pkg::OP_READ,  8'h00, 10'd5,    1, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, "z",   10'd0,    0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, 8'hFF, 10'd0,    0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, 8'h00, 10'd0,    0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, "_",   10'd0,    0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_READ,  8'h00, 10'd12,   0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, LINE_FEED, 10'd0, 0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, "7",   10'd0,    0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_READ,  8'h00, 10'd128,  0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_BEGIN, 8'h00, 10'd0,    1, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_READ,  8'h00, 10'd128,  1, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, LINE_FEED, 10'd0, 0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, LINE_FEED, 10'd0, 0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, LINE_FEED, 10'd0, 0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, LINE_FEED, 10'd0, 0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, LINE_FEED, 10'd0, 0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, LINE_FEED, 10'd0, 0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, LINE_FEED, 10'd0, 0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, LINE_FEED, 10'd0, 0, 8'h00, 0, 0),
         row(ttpfb_pkg::OP_PLACE, "Q",   10'd0,    1, 8'h00, 0, 1),
         row(OP_SPARE,            8'h00, 10'd0,    1, 8'h00, 0, 1),
         row(ttpfb_pkg::OP_READ,  8'h00, 10'd1023, 1, 8'h00, 0, 1)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         send(script[k].item, script[k].pinned, script[k].want);
         pace();
      end

      issued  = 0;
      session = 0;
      while (issued < RANDOM_ITEMS) begin
         if (session % 3 == 0) drain();
         item.opcode       = ttpfb_pkg::OP_BEGIN;
         item.char_code    = 8'($urandom_range(0, 255));
         item.read_address = 10'($urandom_range(0, 1023));
         send(item, 1'b0, '0);
         issued++;
         pace();
         nl_pct = ($urandom_range(0, 1) == 0) ? 8 : 1;
         len    = $urandom_range(10, 300);
         for (j = 0; j < len && issued < RANDOM_ITEMS; j++) begin
            pick              = $urandom_range(0, 99);
            item.char_code    = 8'($urandom_range(0, 255));
            item.read_address = 10'($urandom_range(0, 1023));
            counts            = 1'b1;
            if (pick < 70) begin
               item.opcode    = ttpfb_pkg::OP_PLACE;
               item.char_code = pick_char(nl_pct);
               counts         = !page_full;
            end else if (pick < 94) begin
               item.opcode = ttpfb_pkg::OP_READ;
               if ($urandom_range(0, 1) == 0)
                  item.read_address = 10'(pen_page * COLUMNS + $urandom_range(0, COLUMNS - 1));
            end else begin
               item.opcode = OP_SPARE;
            end
            send(item, 1'b0, '0);
            if (counts) issued++;
            pace();
            if (page_full && $urandom_range(0, 15) == 0) break;
         end
         session++;
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* text_to_page_framebuffer_unit.f */
hw/rtl/ttpfb_pkg.sv
hw/rtl/ttpfb_ctrl.sv
hw/rtl/ttpfb_datapath.sv
hw/rtl/text_to_page_framebuffer_unit.sv
tb/sv/text_to_page_framebuffer_unit_tb.sv
